### hdl/rrjs_pkg.sv
package rrjs_pkg;

	// Result codes
	typedef enum logic [2:0] {
		EV_IDLE   = 3'd0,
		EV_RAN    = 3'd1,
		EV_FINISH = 3'd2,
		EV_ROTATE = 3'd3,
		EV_ACCEPT = 3'd4,
		EV_REJECT = 3'd5
	} rr_event_t;

	// Operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	localparam int ID_W      = 16;
	localparam int TIME_W    = 10;
	localparam int QCOUNT_W  = 9;

	localparam logic [TIME_W-1:0] QUANTUM_RESET = 10'd50;
	localparam logic [ID_W-1:0]   FIRST_ID      = 16'd1;

	// One queue entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] units;
	} job_entry_t;

endpackage

### hdl/round_robin_job_scheduler.sv
// Channel  | Ports                                         | Transfer when
// ---------+-----------------------------------------------+---------------------------
// command  | start, busy, operation, job_time              | start high, busy low
// result   | done, event_res, job_id, remaining,           | done high (one cycle,
//          | queue_count                                   | no back-pressure)
// config   | quantum_we, quantum_wdata                     | quantum_we high
//
// One command per cycle; its result shows with done in the cycle after the transfer.
// busy stays low: head and second entry live in registers, and the third entry is
// read ahead from the single-port-write job RAM so a pop never waits on the RAM.
// Reset clears pointers, count and slice, and sets id counter and quantum; RAM contents
// are don't-care (no clearing pass). The result side cannot stall: nothing is held back.
module round_robin_job_scheduler #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [9:0]  job_time,
	input  logic        quantum_we,
	input  logic [9:0]  quantum_wdata,
	output logic        done,
	output logic [2:0]  event_res,
	output logic [15:0] job_id,
	output logic [9:0]  remaining,
	output logic [8:0]  queue_count
);

	import rrjs_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = $bits(job_entry_t);

	// Slot after p on the circular queue
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// Control state
	logic [AW-1:0]     head_q, tail_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] slice_q;
	logic [ID_W-1:0]   next_id_q;
	logic [TIME_W-1:0] quantum_q;

	// Cached first and second entries; third comes from the RAM read port or the write bypass
	job_entry_t hd_q, nx_q;
	logic       byp_sel_q;
	job_entry_t byp_q;
	logic [EW-1:0] ram_rdata;
	job_entry_t third;

	// Result register
	logic              done_q;
	rr_event_t         ev_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] rem_q;
	logic [QCOUNT_W-1:0] qc_q;

	// Next-state values
	logic [AW-1:0]     head_d, tail_d, rd_addr;
	logic [CW-1:0]     count_d;
	logic [TIME_W-1:0] slice_d;
	logic [ID_W-1:0]   next_id_d;
	job_entry_t        hd_d, nx_d, wr_data, new_job, rot_job;
	logic              wr_en, accept, full;
	rr_event_t         ev_d;
	logic [ID_W-1:0]   oid_d;
	logic [TIME_W-1:0] orem_d;
	logic [TIME_W-1:0] head_rem;
	logic [TIME_W:0]   used;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign third  = byp_sel_q ? byp_q : job_entry_t'(ram_rdata);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		slice_d   = slice_q;
		next_id_d = next_id_q;
		hd_d      = hd_q;
		nx_d      = nx_q;
		wr_en     = 1'b0;
		wr_data   = hd_q;
		ev_d      = EV_IDLE;
		oid_d     = '0;
		orem_d    = '0;

		// time left on the head after one more unit, and its slice counting that unit
		head_rem = (hd_q.units == '0) ? '0 : hd_q.units - TIME_W'(1);
		used     = {1'b0, slice_q} + (TIME_W+1)'(1);

		new_job.id    = next_id_q;
		new_job.units = job_time;
		rot_job.id    = hd_q.id;
		rot_job.units = head_rem;

		if (accept) begin
			if (operation == OP_ADD) begin
				if (full) begin
					ev_d = EV_REJECT;
				end else begin
					wr_en     = 1'b1;
					wr_data   = new_job;
					tail_d    = slot_inc(tail_q);
					count_d   = count_q + CW'(1);
					next_id_d = next_id_q + ID_W'(1);
					if (count_q == CW'(0)) begin
						hd_d = new_job;
					end else if (count_q == CW'(1)) begin
						nx_d = new_job;
					end
					ev_d   = EV_ACCEPT;
					oid_d  = next_id_q;
					orem_d = job_time;
				end
			end else if (count_q == CW'(0)) begin
				ev_d = EV_IDLE;
			end else if (head_rem == '0) begin
				// finish wins over rotation
				head_d  = slot_inc(head_q);
				count_d = count_q - CW'(1);
				slice_d = '0;
				hd_d    = nx_q;
				nx_d    = third;
				ev_d    = EV_FINISH;
				oid_d   = hd_q.id;
			end else if (used >= {1'b0, quantum_q}) begin
				// head goes to the tail; with a full queue tail slot == head slot
				wr_en   = 1'b1;
				wr_data = rot_job;
				tail_d  = slot_inc(tail_q);
				head_d  = slot_inc(head_q);
				slice_d = '0;
				if (count_q == CW'(1)) begin
					hd_d = rot_job;
				end else begin
					hd_d = nx_q;
					nx_d = (count_q == CW'(2)) ? rot_job : third;
				end
				ev_d   = EV_ROTATE;
				oid_d  = hd_q.id;
				orem_d = head_rem;
			end else begin
				hd_d.units = head_rem;
				slice_d    = used[TIME_W-1:0];
				ev_d       = EV_RAN;
				oid_d      = hd_q.id;
				orem_d     = head_rem;
			end
		end

		// prefetch the entry that will be third after this cycle
		rd_addr = slot_inc(slot_inc(head_d));
	end

	rrjs_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tail_q),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			slice_q   <= '0;
			next_id_q <= FIRST_ID;
			quantum_q <= QUANTUM_RESET;
			byp_sel_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			slice_q   <= slice_d;
			next_id_q <= next_id_d;
			// RAM returns old data on a collision: take the write instead
			byp_sel_q <= wr_en && (tail_q == rd_addr);
			done_q    <= accept;
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		hd_q  <= hd_d;
		nx_q  <= nx_d;
		byp_q <= wr_data;
		if (accept) begin
			ev_q  <= ev_d;
			id_q  <= oid_d;
			rem_q <= orem_d;
			qc_q  <= QCOUNT_W'(count_d);
		end
	end

	assign done        = done_q;
	assign event_res   = ev_q;
	assign job_id      = id_q;
	assign remaining   = rem_q;
	assign queue_count = qc_q;

endmodule

### hdl/rrjs_ram.sv
module rrjs_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/rrjs_checker.sv
module rrjs_checker #(
	parameter int QUEUE_DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  event_res,
	input logic [15:0] job_id,
	input logic [9:0]  remaining,
	input logic [8:0]  queue_count
);

	import rrjs_pkg::*;

	// every transfer gives exactly one result, next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after command transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without command transfer");

	// reject only when the queue holds QUEUE_DEPTH jobs
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && event_res == EV_REJECT) |-> (queue_count == 9'(QUEUE_DEPTH)))
		else $error("reject with queue not full");

	// idle tick and finish report fixed fields
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && event_res == EV_IDLE) |->
		(job_id == '0 && remaining == '0 && queue_count == '0))
		else $error("idle tick fields not zero");

	a_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && event_res == EV_FINISH) |-> (remaining == '0))
		else $error("finished job with time left");

endmodule

bind round_robin_job_scheduler rrjs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rrjs_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Round-robin job scheduler check: a command driver and a result monitor run off
// one clock. Every command transfer updates a local copy of the job queue and
// pushes the result it must produce; each done strobe is compared against the
// oldest such result.
module testbench;
	import rrjs_pkg::*;

	localparam int JOB_SLOTS   = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PRINT_CAP   = 30;

	// One command as queued for the driver
	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] jt;
	} sched_cmd_t;

	// One result as the scheduler must report it
	typedef struct packed {
		rr_event_t           ev;
		logic [ID_W-1:0]     id;
		logic [TIME_W-1:0]   rem;
		logic [QCOUNT_W-1:0] cnt;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = OP_TICK;
	logic [9:0]  job_time = '0;
	logic        quantum_we = 1'b0;
	logic [9:0]  quantum_wdata = '0;
	logic        done;
	logic [2:0]  event_res;
	logic [15:0] job_id;
	logic [9:0]  remaining;
	logic [8:0]  queue_count;

	round_robin_job_scheduler #(
		.QUEUE_DEPTH(JOB_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.job_time     (job_time),
		.quantum_we   (quantum_we),
		.quantum_wdata(quantum_wdata),
		.done         (done),
		.event_res    (event_res),
		.job_id       (job_id),
		.remaining    (remaining),
		.queue_count  (queue_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Scheduler shadow: circular job queue, slice counter, id counter
	// ------------------------------------------------------------------
	logic [ID_W-1:0]   slot_id   [JOB_SLOTS];
	logic [TIME_W-1:0] slot_time [JOB_SLOTS];
	int unsigned       q_head = 0;
	int unsigned       q_tail = 0;
	int unsigned       q_count = 0;
	int unsigned       slice_cnt = 0;
	logic [ID_W-1:0]   id_next = FIRST_ID;
	logic [TIME_W-1:0] quantum_cfg = QUANTUM_RESET;

	sched_cmd_t    pending_cmds [$];
	sched_result_t due_results  [$];

	int  send_gap_pct = 0;
	logic cmd_taken = 1'b0;
	int  err_count = 0;
	int  xfer_count = 0;
	int  cycle_count = 0;
	int  quantum_writes = 0;
	int  peak_count = 0;
	int  ev_seen [6];

	// Works out the result of one transferred command and advances the shadow.
	task automatic apply_command(input logic op, input logic [TIME_W-1:0] jt);
		sched_result_t     r;
		logic [ID_W-1:0]   hid;
		logic [TIME_W-1:0] left;
		int unsigned       used;
		r = '0;
		r.cnt = QCOUNT_W'(q_count);
		if (op == OP_ADD) begin
			if (q_count >= JOB_SLOTS) begin
				r.ev = EV_REJECT;          // full: no id consumed
			end else begin
				slot_id[q_tail]   = id_next;
				slot_time[q_tail] = jt;
				q_tail  = (q_tail + 1) % JOB_SLOTS;
				q_count = q_count + 1;
				r.ev  = EV_ACCEPT;
				r.id  = id_next;
				r.rem = jt;
				r.cnt = QCOUNT_W'(q_count);
				id_next = id_next + 1'b1;  // wraps at 16 bits
			end
		end else if (q_count == 0) begin
			r.ev = EV_IDLE;                // all fields zero, nothing changes
		end else begin
			hid  = slot_id[q_head];
			left = (slot_time[q_head] == 0) ? '0 : slot_time[q_head] - 1'b1;
			used = slice_cnt + 1;
			r.id  = hid;
			r.rem = left;
			if (left == 0) begin
				// finish wins over rotation; zero-time jobs land here too
				q_head    = (q_head + 1) % JOB_SLOTS;
				q_count   = q_count - 1;
				slice_cnt = 0;
				r.ev  = EV_FINISH;
				r.cnt = QCOUNT_W'(q_count);
			end else if (used >= quantum_cfg) begin
				// quantum 0 acts as 1; on a full queue tail and head are one slot
				slot_id[q_tail]   = hid;
				slot_time[q_tail] = left;
				q_tail    = (q_tail + 1) % JOB_SLOTS;
				q_head    = (q_head + 1) % JOB_SLOTS;
				slice_cnt = 0;
				r.ev = EV_ROTATE;
			end else begin
				slot_time[q_head] = left;
				slice_cnt = used;
				r.ev = EV_RAN;
			end
		end
		due_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("mismatch %0s: got %0d, expected %0d (cycle %0d)",
				what, got, want, cycle_count);
	endtask

	task automatic queue_cmd(input logic op, input logic [TIME_W-1:0] jt);
		sched_cmd_t c;
		c.op = op;
		c.jt = jt;
		pending_cmds.push_back(c);
	endtask

	// Config writes only happen with nothing in flight, so the shadow can
	// switch over at once.
	task automatic write_quantum(input logic [TIME_W-1:0] v);
		@(negedge clk);
		quantum_we    <= 1'b1;
		quantum_wdata <= v;
		quantum_cfg = v;
		quantum_writes++;
		@(negedge clk);
		quantum_we    <= 1'b0;
		quantum_wdata <= 10'($urandom);
	endtask

	// Block until every queued command has transferred and its result has shown.
	task automatic wait_quiet;
		while (pending_cmds.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Command driver: changes inputs on the falling edge. A new command is
	// offered only once the previous one has transferred; send_gap_pct sets
	// how often the slot is left empty instead.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_cmds
		sched_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || cmd_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = pending_cmds.pop_front();
				start     <= 1'b1;
				operation <= nxt.op;
				job_time  <= nxt.jt;
			end else begin
				// idle slot: payload is junk on purpose
				start     <= 1'b0;
				operation <= 1'($urandom);
				job_time  <= 10'($urandom);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: on the rising edge, record a command transfer (predict first,
	// so a same-cycle result would still find its expectation), then check
	// any result strobe against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		sched_result_t want;
		cycle_count <= cycle_count + 1;
		cmd_taken   <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			apply_command(operation, job_time);
			xfer_count++;
		end
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result, event", event_res, -1);
			end else begin
				want = due_results.pop_front();
				if (event_res !== want.ev)
					report_mismatch("event_res", event_res, want.ev);
				if (job_id !== want.id)
					report_mismatch("job_id", job_id, want.id);
				if (remaining !== want.rem)
					report_mismatch("remaining", remaining, want.rem);
				if (queue_count !== want.cnt)
					report_mismatch("queue_count", queue_count, want.cnt);
				if (want.ev <= EV_REJECT)
					ev_seen[want.ev]++;
				if (int'(want.cnt) > peak_count)
					peak_count = want.cnt;
			end
		end
	end

	// Safety net against a hung handshake
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, due_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Phases
	// ------------------------------------------------------------------
	initial begin : run_phases
		int k;
		logic op;
		foreach (ev_seen[i]) ev_seen[i] = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset quantum: idle ticks, zero-time job, time extremes,
		// alternating bit patterns in job_time.
		send_gap_pct = 0;
		queue_cmd(OP_TICK, 10'h3FF);   // empty queue -> idle
		queue_cmd(OP_ADD,  10'd0);     // zero-time job accepted
		queue_cmd(OP_TICK, 10'd0);     // ...finishes on first tick
		queue_cmd(OP_TICK, 10'h155);   // idle again
		queue_cmd(OP_ADD,  10'd1);
		queue_cmd(OP_TICK, 10'h2AA);   // finish from time 1
		queue_cmd(OP_ADD,  10'h3FF);
		queue_cmd(OP_ADD,  10'd2);
		queue_cmd(OP_ADD,  10'h2AA);
		queue_cmd(OP_TICK, 10'd0);     // head runs, 1022 left
		queue_cmd(OP_TICK, 10'd0);
		queue_cmd(OP_ADD,  10'h155);
		queue_cmd(OP_TICK, 10'h3FF);
		wait_quiet();

		// Quantum 1, sender idles about a third of the time: short jobs,
		// rotation on every tick that does not finish.
		write_quantum(10'd1);
		send_gap_pct = 32;
		for (k = 0; k < 150; k++) begin
			if (k == 75)
				wait_quiet();          // pause until all results are back
			op = 1'($urandom);
			if (op == OP_ADD && $urandom_range(7) == 0)
				queue_cmd(OP_ADD, 10'($urandom_range(1023)));
			else if (op == OP_ADD)
				queue_cmd(OP_ADD, 10'($urandom_range(15)));
			else
				queue_cmd(OP_TICK, 10'($urandom));
		end
		wait_quiet();

		// Quantum at its top, sender idles about half the time: a long run
		// of adds fills the queue and then gets rejected.
		write_quantum(10'd1023);
		send_gap_pct = 52;
		for (k = 0; k < 270; k++)
			queue_cmd(OP_ADD, 10'($urandom_range(1023)));
		for (k = 0; k < 20; k++)
			queue_cmd(1'($urandom), 10'($urandom_range(1023)));
		wait_quiet();

		// Quantum 0 on a full queue: every tick that does not finish rotates head into the same
		// slot, adds bounce until something finishes. No idling.
		write_quantum(10'd0);
		send_gap_pct = 0;
		for (k = 0; k < 60; k++) begin
			if ($urandom_range(4) == 0)
				queue_cmd(OP_ADD, 10'($urandom_range(3)));
			else
				queue_cmd(OP_TICK, 10'($urandom));
		end
		wait_quiet();

		// Some middle quantum, mixed traffic, no idling
		write_quantum(10'($urandom_range(2, 40)));
		for (k = 0; k < 40; k++) begin
			if ($urandom_range(2) == 0)
				queue_cmd(OP_ADD, 10'($urandom_range(1023)));
			else
				queue_cmd(OP_TICK, 10'($urandom));
		end
		wait_quiet();

		while (due_results.size() != 0) begin
			void'(due_results.pop_front());
			report_mismatch("missing result, count", 0, 1);
		end

		$display("%0d command transfers under %0d quantum writes; queue peaked at %0d of %0d",
			xfer_count, quantum_writes, peak_count, JOB_SLOTS);
		$display("events idle/ran/finish/rotate/accept/reject: %0d/%0d/%0d/%0d/%0d/%0d",
			ev_seen[EV_IDLE], ev_seen[EV_RAN], ev_seen[EV_FINISH],
			ev_seen[EV_ROTATE], ev_seen[EV_ACCEPT], ev_seen[EV_REJECT]);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/rrjs_pkg.sv
hdl/rrjs_ram.sv
hdl/round_robin_job_scheduler.sv
hdl/rrjs_checker.sv
tb/sv/testbench.sv
